// ----- sv/tfhc_pkg.sv -----
// Shared types, constants and register map of the tank fill and heat controller.
`default_nettype none

package tfhc_pkg;

  // Converter width and configuration port geometry
  localparam int ADC_BITS_DEFAULT = 10;
  localparam int APB_ADDR_W       = 4;
  localparam int APB_DATA_W       = 32;
  localparam int TICK_W           = 8;
  localparam int THRESH_W         = 10;

  // Register reset values
  localparam int FILL_TIMEOUT_RESET  = 200;
  localparam int SAMPLE_PERIOD_RESET = 200;
  localparam int HEAT_THRESH_RESET   = 472;

  // Register indexes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_FILL_TIMEOUT  = 2'd0,
    REG_SAMPLE_PERIOD = 2'd1,
    REG_HEAT_THRESH   = 2'd2
  } reg_idx_t;

  // Controller state; the drive bits are also the result of each tick
  typedef struct packed {
    logic              first_fill_done;
    logic              maint_latched;
    logic              pump;
    logic              drain;
    logic              heater;
    logic              run_led;
    logic              heat_led;
    logic [TICK_W-1:0] fill_ticks;
    logic [TICK_W-1:0] sample_ticks;
  } ctrl_state_t;

  // One sampled set of switches and sensors, less the converter code
  typedef struct packed {
    logic run_switch;
    logic low_level;
    logic high_level;
    logic heat_enable;
    logic maint_n;
  } sample_t;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

endpackage

`default_nettype wire

// ----- sv/tfhc_step.sv -----
// Next-state logic for one 50 ms tick of the tank fill and heat controller.
`default_nettype none

module tfhc_step #(
  parameter int ADC_BITS = tfhc_pkg::ADC_BITS_DEFAULT
) (
  input  wire tfhc_pkg::ctrl_state_t             cur,
  input  wire tfhc_pkg::sample_t                 smp,
  input  wire logic [ADC_BITS-1:0]               temp_code,
  input  wire logic [tfhc_pkg::TICK_W-1:0]       fill_timeout_ticks,
  input  wire logic [tfhc_pkg::TICK_W-1:0]       sample_period_ticks,
  input  wire logic [tfhc_pkg::THRESH_W-1:0]     heat_threshold_code,
  output tfhc_pkg::ctrl_state_t                  nxt
);

  // Code and threshold compared at the wider of the two widths
  localparam int CMP_W = (ADC_BITS > tfhc_pkg::THRESH_W) ? ADC_BITS : tfhc_pkg::THRESH_W;

  logic [CMP_W-1:0] code_ext;
  logic [CMP_W-1:0] thresh_ext;

  assign code_ext   = CMP_W'(temp_code);
  assign thresh_ext = CMP_W'(heat_threshold_code);

  // Decisions are taken in order, each on what the previous ones left
  always_comb begin
    nxt = cur;
    if (!smp.maint_n) begin
      // Maintenance: everything off, remember it
      nxt.pump          = 1'b0;
      nxt.drain         = 1'b0;
      nxt.heater        = 1'b0;
      nxt.run_led       = 1'b0;
      nxt.heat_led      = 1'b0;
      nxt.fill_ticks    = '0;
      nxt.sample_ticks  = '0;
      nxt.maint_latched = 1'b1;
    end else if (!smp.run_switch || cur.maint_latched) begin
      // Idle, also the first tick after maintenance
      nxt.pump            = 1'b0;
      nxt.drain           = 1'b0;
      nxt.heater          = 1'b0;
      nxt.run_led         = 1'b0;
      nxt.heat_led        = 1'b0;
      nxt.fill_ticks      = '0;
      nxt.sample_ticks    = '0;
      nxt.first_fill_done = 1'b0;
      nxt.maint_latched   = 1'b0;
    end else begin
      nxt.run_led = 1'b1;
      // Heat control dropped while pumping or once switched off
      if (cur.pump || (!smp.heat_enable && cur.first_fill_done)) begin
        nxt.heat_led     = 1'b0;
        nxt.heater       = 1'b0;
        nxt.sample_ticks = '0;
      end
      // Start filling at first run or when the low sensor uncovers
      if (!cur.first_fill_done || !smp.low_level) begin
        nxt.pump            = 1'b1;
        nxt.drain           = 1'b0;
        nxt.first_fill_done = 1'b1;
      end
      // Stop on full or timeout, open the drain
      if (nxt.pump && (cur.fill_ticks >= fill_timeout_ticks || smp.high_level)) begin
        nxt.pump       = 1'b0;
        nxt.drain      = 1'b1;
        nxt.fill_ticks = '0;
      end
      // Temperature evaluation once per sample period
      if (smp.heat_enable && !nxt.pump) begin
        nxt.heat_led = 1'b1;
        if (nxt.sample_ticks >= sample_period_ticks) begin
          nxt.sample_ticks = '0;
          nxt.heater       = (code_ext <= thresh_ext);
        end
      end
      // Count the tick, saturating
      if (nxt.pump && nxt.fill_ticks != tfhc_pkg::TICK_MAX)
        nxt.fill_ticks = nxt.fill_ticks + 1'b1;
      if (smp.heat_enable && !nxt.pump && nxt.sample_ticks != tfhc_pkg::TICK_MAX)
        nxt.sample_ticks = nxt.sample_ticks + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tank_fill_heat_controller_core.sv -----
// Top level of the tank fill and heat controller: handshakes, registers, state.
// One input transaction is one 50 ms sample of the switches, level sensors and
// temperature code; it yields exactly one result transaction carrying the five
// drive outputs as they stand after that tick. The tick is evaluated by the
// next-state logic into the state register, which doubles as the result
// register, so a new sample is taken every cycle as long as the previous
// result has been taken or is taken in the same cycle. The heater switches
// on when temp_code is at or below heat_threshold_code (reset 472). Registers:
// 0x0 fill timeout ticks, 0x4 sample period ticks, 0x8 heat threshold code;
// write them only while the block is idle.
`default_nettype none

module tank_fill_heat_controller_core #(
  parameter int ADC_BITS = tfhc_pkg::ADC_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tfhc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [tfhc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tfhc_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready,
  // Sample channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                run_switch,
  input  wire logic                                low_level,
  input  wire logic                                high_level,
  input  wire logic                                heat_enable,
  input  wire logic                                maint_n,
  input  wire logic [ADC_BITS-1:0]                 temp_code,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     pump_on,
  output logic                                     drain_open,
  output logic                                     heater_on,
  output logic                                     run_led,
  output logic                                     heat_led
);

  localparam int TW = tfhc_pkg::TICK_W;
  localparam int HW = tfhc_pkg::THRESH_W;

  logic [TW-1:0]       fill_timeout_ticks;
  logic [TW-1:0]       sample_period_ticks;
  logic [HW-1:0]       heat_threshold_code;

  tfhc_pkg::ctrl_state_t state;
  tfhc_pkg::ctrl_state_t state_next;
  tfhc_pkg::sample_t     smp;
  tfhc_pkg::reg_idx_t    reg_idx;

  logic in_accept;
  logic cfg_write;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = tfhc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_timeout_ticks  <= TW'(tfhc_pkg::FILL_TIMEOUT_RESET);
      sample_period_ticks <= TW'(tfhc_pkg::SAMPLE_PERIOD_RESET);
      heat_threshold_code <= HW'(tfhc_pkg::HEAT_THRESH_RESET);
    end else if (cfg_write) begin
      unique case (reg_idx)
        tfhc_pkg::REG_FILL_TIMEOUT:  fill_timeout_ticks  <= pwdata[TW-1:0];
        tfhc_pkg::REG_SAMPLE_PERIOD: sample_period_ticks <= pwdata[TW-1:0];
        tfhc_pkg::REG_HEAT_THRESH:   heat_threshold_code <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      tfhc_pkg::REG_FILL_TIMEOUT:  prdata = tfhc_pkg::APB_DATA_W'(fill_timeout_ticks);
      tfhc_pkg::REG_SAMPLE_PERIOD: prdata = tfhc_pkg::APB_DATA_W'(sample_period_ticks);
      tfhc_pkg::REG_HEAT_THRESH:   prdata = tfhc_pkg::APB_DATA_W'(heat_threshold_code);
      default:                     prdata = '0;
    endcase
  end

  // Handshake: a sample is taken whenever the result slot is free or draining
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign smp.run_switch  = run_switch;
  assign smp.low_level   = low_level;
  assign smp.high_level  = high_level;
  assign smp.heat_enable = heat_enable;
  assign smp.maint_n     = maint_n;

  tfhc_step #(
    .ADC_BITS (ADC_BITS)
  ) u_step (
    .cur                 (state),
    .smp                 (smp),
    .temp_code           (temp_code),
    .fill_timeout_ticks  (fill_timeout_ticks),
    .sample_period_ticks (sample_period_ticks),
    .heat_threshold_code (heat_threshold_code),
    .nxt                 (state_next)
  );

  // State register, also holding the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign pump_on    = state.pump;
  assign drain_open = state.drain;
  assign heater_on  = state.heater;
  assign run_led    = state.run_led;
  assign heat_led   = state.heat_led;

  // Maintenance turns every drive off in the result of that transaction
  a_maint_off: assert property (@(posedge clk) disable iff (rst)
    in_accept && !maint_n |=> out_valid && !pump_on && !drain_open && !heater_on
                              && !run_led && !heat_led)
    else $error("maintenance transaction left a drive on");

  // Run switch off gives an idle result
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    in_accept && maint_n && !run_switch |=> !pump_on && !drain_open && !heater_on
                                             && !run_led && !heat_led)
    else $error("idle transaction left a drive on");

  // Pump and drain are never driven together
  a_pump_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pump_on && drain_open))
    else $error("pump and drain both on");

  // Heater only under active temperature control, which needs run
  a_heater_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!heater_on || heat_led) && (!heat_led || run_led))
    else $error("heater or heat lamp on without its enabling indication");

endmodule

`default_nettype wire

// ----- sim/tfhc_checker.sv -----
// Drive-output checker for the tank controller: mirrors registers, predicts every tick.
`timescale 1ns / 100ps

module tfhc_checker #(
  parameter int ADC_BITS = tfhc_pkg::ADC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port, watched only
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [tfhc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tfhc_pkg::APB_DATA_W-1:0] pwdata,
  // Sample channel
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            run_switch,
  input  logic                            low_level,
  input  logic                            high_level,
  input  logic                            heat_enable,
  input  logic                            maint_n,
  input  logic [ADC_BITS-1:0]             temp_code,
  // Drive channel
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            pump_on,
  input  logic                            drain_open,
  input  logic                            heater_on,
  input  logic                            run_led,
  input  logic                            heat_led,
  // To the testbench top
  output int                              mismatches,
  output int                              drives_pending
);
  import tfhc_pkg::*;

  // Register mirror
  logic [TICK_W-1:0] fill_limit;
  logic [TICK_W-1:0] sample_limit;
  logic [9:0]        heat_limit;

  // Controller mirror and drive sets still to arrive, {pump, drain, heater, run, heat}
  ctrl_state_t plant;
  logic [4:0]  drives_due[$];
  logic [4:0]  got;
  logic [4:0]  want;
  int          fail_tally = 0;
  string       drive_name [5] = '{"heat_led", "run_led", "heater_on", "drain_open", "pump_on"};

  // Everything off, counters cleared
  function automatic ctrl_state_t drives_cleared(ctrl_state_t s);
    ctrl_state_t n;
    n = s;
    n.pump         = 1'b0;
    n.drain        = 1'b0;
    n.heater       = 1'b0;
    n.run_led      = 1'b0;
    n.heat_led     = 1'b0;
    n.fill_ticks   = '0;
    n.sample_ticks = '0;
    return n;
  endfunction

  // One 50 ms tick: decisions on the current counters, then the tick is counted
  function automatic ctrl_state_t tick_plant(ctrl_state_t s, sample_t x,
                                             logic [ADC_BITS-1:0] code);
    ctrl_state_t n;
    n = s;
    if (!x.maint_n) begin
      n = drives_cleared(n);
      n.maint_latched = 1'b1;
    end else if (!x.run_switch || n.maint_latched) begin
      n = drives_cleared(n);
      n.first_fill_done = 1'b0;
      n.maint_latched   = 1'b0;
    end else begin
      n.run_led = 1'b1;
      // heat control drops out while pumping or once switched off
      if (n.pump || (!x.heat_enable && n.first_fill_done)) begin
        n.heat_led     = 1'b0;
        n.heater       = 1'b0;
        n.sample_ticks = '0;
      end
      if (!n.first_fill_done || !x.low_level) begin
        n.pump            = 1'b1;
        n.drain           = 1'b0;
        n.first_fill_done = 1'b1;
      end
      // full tank or timeout ends the fill
      if (n.pump && (n.fill_ticks >= fill_limit || x.high_level)) begin
        n.pump       = 1'b0;
        n.drain      = 1'b1;
        n.fill_ticks = '0;
      end
      if (x.heat_enable && !n.pump) begin
        n.heat_led = 1'b1;
        if (n.sample_ticks >= sample_limit) begin
          n.sample_ticks = '0;
          n.heater       = (code <= heat_limit);
        end
      end
      if (n.pump && n.fill_ticks != TICK_MAX)
        n.fill_ticks = n.fill_ticks + 1'b1;
      if (x.heat_enable && !n.pump && n.sample_ticks != TICK_MAX)
        n.sample_ticks = n.sample_ticks + 1'b1;
    end
    return n;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_limit   = TICK_W'(FILL_TIMEOUT_RESET);
      sample_limit = TICK_W'(SAMPLE_PERIOD_RESET);
      heat_limit   = 10'(HEAT_THRESH_RESET);
      plant        = '0;
      drives_due.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FILL_TIMEOUT:  fill_limit   = pwdata[TICK_W-1:0];
          REG_SAMPLE_PERIOD: sample_limit = pwdata[TICK_W-1:0];
          REG_HEAT_THRESH:   heat_limit   = pwdata[9:0];
          default: ;
        endcase
      end
      // drive transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        got = {pump_on, drain_open, heater_on, run_led, heat_led};
        if (drives_due.size() == 0) begin
          $display("%0t: drive transaction with none outstanding: expected none, got %b",
                   $time, got);
          fail_tally++;
        end else begin
          want = drives_due.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: %s expected %b, got %b", $time, drive_name[i], want[i], got[i]);
              fail_tally++;
            end
          end
        end
      end
      // sample transaction: advance the mirror
      if (in_valid && !in_stall) begin
        plant = tick_plant(plant, {run_switch, low_level, high_level, heat_enable, maint_n},
                           temp_code);
        drives_due.push_back({plant.pump, plant.drain, plant.heater, plant.run_led,
                              plant.heat_led});
      end
    end
    mismatches     <= fail_tally;
    drives_pending <= drives_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the tank controller: sample stimulus, stalls, register set-up, verdict.
`timescale 1ns / 100ps

module tb_top;
  import tfhc_pkg::*;

  localparam int CODE_W      = ADC_BITS_DEFAULT;
  localparam int QUIET_LIMIT = 2000;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  run_switch  = 1'b0;
  logic                  low_level   = 1'b0;
  logic                  high_level  = 1'b0;
  logic                  heat_enable = 1'b0;
  logic                  maint_n     = 1'b1;
  logic [CODE_W-1:0]     temp_code   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  pump_on;
  logic                  drain_open;
  logic                  heater_on;
  logic                  run_led;
  logic                  heat_led;
  int                    mismatches;
  int                    drives_pending;

  int                    tx_idle_pct = 36;
  int                    rx_idle_pct = 46;
  logic [9:0]            thresh_now  = 10'(HEAT_THRESH_RESET);
  int                    quiet_cycles = 0;

  tank_fill_heat_controller_core dut (.*);

  tfhc_checker drive_check (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < rx_idle_pct);

  // watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample transaction, with random gaps ahead of it
  task automatic send_sample(input sample_t s, input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {run_switch, low_level, high_level, heat_enable, maint_n} <= s;
    temp_code <= code;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every drive set has come back, plus a little slack
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (drives_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_HEAT_THRESH)
      thresh_now = value[9:0];
  endtask

  task automatic load_settings(input int fill, input int period, input int thresh);
    write_reg(REG_FILL_TIMEOUT, fill);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_HEAT_THRESH, thresh);
  endtask

  // Mostly runs of plausible plant behaviour, the rest random noise
  task automatic random_phase(input int items, input int full_pct);
    int                left;
    int                span;
    bit                plausible;
    logic              heat;
    sample_t           s;
    logic [CODE_W-1:0] code;
    left = items;
    while (left > 0) begin
      span = $urandom_range(40, 4);
      if (span > left)
        span = left;
      plausible = ($urandom_range(99) < 85);
      heat      = ($urandom_range(1) != 0);
      for (int k = 0; k < span; k++) begin
        if (plausible) begin
          if ($urandom_range(29) == 0)
            heat = !heat;
          s.run_switch  = ($urandom_range(249) != 0);
          s.low_level   = ($urandom_range(99) >= 12);
          s.high_level  = ($urandom_range(99) < full_pct);
          s.heat_enable = heat;
          s.maint_n     = ($urandom_range(249) != 0);
          // codes around the threshold a third of the time
          if ($urandom_range(2) == 0)
            code = thresh_now ^ CODE_W'($urandom_range(3));
          else
            code = CODE_W'($urandom);
        end else begin
          s    = sample_t'($urandom);
          code = CODE_W'($urandom);
        end
        send_sample(s, code);
      end
      left -= span;
    end
  endtask

  // Field order of the sample literals: {run, low, high, heat, maint_n}
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // maintenance, idle after it, first fill counting at reset values
    send_sample(5'b11110, 10'd1023);
    send_sample(5'b11001, 10'd0);
    send_sample(5'b11001, 10'd0);
    send_sample(5'b11001, 10'd0);
    send_sample(5'b11001, 10'd0);

    // lowered timeout takes effect mid-fill; sample every tick
    settle();
    write_reg(REG_FILL_TIMEOUT, 2);
    write_reg(REG_SAMPLE_PERIOD, 0);
    send_sample(5'b11001, 10'd0);
    send_sample(5'b11011, 10'd472);
    send_sample(5'b11011, 10'd473);
    send_sample(5'b11011, 10'd0);
    send_sample(5'b11011, 10'd1023);
    send_sample(5'b10111, 10'd200);
    send_sample(5'b10011, 10'd200);
    send_sample(5'b11001, 10'd200);
    send_sample(5'b11001, 10'd200);
    send_sample(5'b01001, 10'd200);
    send_sample(5'b11111, 10'd100);
    send_sample(5'b11011, 10'd100);
    send_sample(5'b11001, 10'd100);

    // zero timeout: fill starts and stops in one tick
    settle();
    write_reg(REG_FILL_TIMEOUT, 0);
    send_sample(5'b10001, 10'd900);
    send_sample(5'b00001, 10'd900);
    send_sample(5'b11001, 10'd900);
    send_sample(5'b00000, 10'd900);

    // random phases over a spread of settings
    settle();
    load_settings(200, 200, 472);
    random_phase(270, 0);
    settle();
    load_settings(1, 1, 0);
    random_phase(270, 10);

    tx_idle_pct = 46;
    rx_idle_pct = 36;
    settle();
    load_settings(255, 255, 1023);
    random_phase(270, 1);
    settle();
    load_settings(0, 3, $urandom_range(1023));
    random_phase(270, 10);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    load_settings($urandom_range(15, 1), $urandom_range(15), $urandom_range(1023));
    random_phase(270, 8);
    settle();
    load_settings(5, 1, 472);
    random_phase(270, 15);

    settle();
    if (mismatches == 0 && drives_pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
